### hw/rtl/vgae_pkg.sv
`default_nettype none

package vgae_pkg;

  // Fixed-point format
  localparam int FRAC_BITS  = 16;
  localparam int VAL_W      = 32;               // Q16.16 values and advantage
  localparam int RATIO_W    = 24;               // Q8.16 ratio and clip limits
  localparam int COEF_W     = FRAC_BITS + 1;    // gamma / lambda, 1.0 included

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATIO_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_LIMIT = 2'd3;

  localparam logic [COEF_W-1:0]  DISCOUNT_RST    = 17'd64881;
  localparam logic [COEF_W-1:0]  TRACE_DECAY_RST = 17'd62259;
  localparam logic [RATIO_W-1:0] RHO_LIMIT_RST   = 24'd65536;
  localparam logic [RATIO_W-1:0] TRACE_LIMIT_RST = 24'd65536;

  // Shared multiplier: signed A x signed B, rounded back to FRAC_BITS
  localparam int MUL_A_W   = 36;                // inner TD term needs 35 bits
  localparam int MUL_B_W   = 27;                // gamma*lambda*c needs 26 bits
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_RES_W = PROD_W - FRAC_BITS;
  localparam int GL_W      = 2 * COEF_W - FRAC_BITS;   // gamma*lambda
  localparam int SUM_W     = MUL_RES_W + 1;

  localparam logic signed [VAL_W-1:0] ADV_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] ADV_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GV,
    ST_MUL_GL,
    ST_MUL_DELTA,
    ST_MUL_GLC,
    ST_MUL_TRACE,
    ST_FINISH
  } seq_state_t;

  typedef enum logic [2:0] {
    SEL_GV,      // gamma * value_next
    SEL_GL,      // gamma * lambda
    SEL_DELTA,   // rho * inner
    SEL_GLC,     // (gamma*lambda) * c
    SEL_TRACE    // (gamma*lambda*c) * previous trace
  } mul_sel_t;

  typedef struct packed {
    logic     idle;
    mul_sel_t op_sel;
    logic     mul_en;
    logic     cap_inner;
    logic     cap_gl;
    logic     cap_delta;
    logic     load_out;
  } ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/vgae_in_if.sv
`default_nettype none

interface vgae_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vgae_pkg::VAL_W-1:0]    value_now;
  logic signed [vgae_pkg::VAL_W-1:0]    value_next;
  logic signed [vgae_pkg::VAL_W-1:0]    reward_next;
  logic                                 terminated_next;
  logic                                 truncated;
  logic        [vgae_pkg::RATIO_W-1:0]  importance_ratio;
  logic                                 row_start;

  modport source (
    output valid, value_now, value_next, reward_next, terminated_next,
           truncated, importance_ratio, row_start,
    input  ready
  );

  modport sink (
    input  valid, value_now, value_next, reward_next, terminated_next,
           truncated, importance_ratio, row_start,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/vgae_out_if.sv
`default_nettype none

interface vgae_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vgae_pkg::VAL_W-1:0] advantage;

  modport source (output valid, advantage, input ready);
  modport sink   (input valid, advantage, output ready);
endinterface

`default_nettype wire

### hw/rtl/vgae_mul.sv
`default_nettype none

// Shared signed multiplier, round to nearest (ties up), registered result.
// The result register only loads while mul_en is high.
module vgae_mul (
  input  wire                                       clk,
  input  wire                                       mul_en,
  input  wire logic signed [vgae_pkg::MUL_A_W-1:0]  mul_a,
  input  wire logic signed [vgae_pkg::MUL_B_W-1:0]  mul_b,
  output logic signed [vgae_pkg::MUL_RES_W-1:0]     prod_r
);

  localparam int PW = vgae_pkg::PROD_W;
  localparam int FB = vgae_pkg::FRAC_BITS;

  localparam logic signed [PW-1:0] ROUND_HALF =
    {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_rnd;

  assign prod     = mul_a * mul_b;
  assign prod_rnd = prod + ROUND_HALF;

  // upper bits = floor of the shift, for either sign
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_rnd[PW-1:FB];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vgae_seq.sv
`default_nettype none

// Step sequencer: issues the five multiplies in order (none for a truncated step), then loads the result.
module vgae_seq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_fire,
  input  wire                   in_trunc,
  input  wire                   out_free,
  output vgae_pkg::ctrl_t       ctrl
);

  vgae_pkg::seq_state_t state_r;
  vgae_pkg::seq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vgae_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ctrl.idle      = 1'b0;
    ctrl.op_sel    = vgae_pkg::SEL_GV;
    ctrl.mul_en    = 1'b0;
    ctrl.cap_inner = 1'b0;
    ctrl.cap_gl    = 1'b0;
    ctrl.cap_delta = 1'b0;
    ctrl.load_out  = 1'b0;
    unique case (state_r)
      vgae_pkg::ST_IDLE: begin
        ctrl.idle = 1'b1;
        if (in_fire) begin
          state_nxt = in_trunc ? vgae_pkg::ST_FINISH : vgae_pkg::ST_MUL_GV;
        end
      end
      vgae_pkg::ST_MUL_GV: begin
        ctrl.op_sel = vgae_pkg::SEL_GV;
        ctrl.mul_en = 1'b1;
        state_nxt   = vgae_pkg::ST_MUL_GL;
      end
      vgae_pkg::ST_MUL_GL: begin
        ctrl.op_sel    = vgae_pkg::SEL_GL;
        ctrl.mul_en    = 1'b1;
        ctrl.cap_inner = 1'b1;
        state_nxt      = vgae_pkg::ST_MUL_DELTA;
      end
      vgae_pkg::ST_MUL_DELTA: begin
        ctrl.op_sel = vgae_pkg::SEL_DELTA;
        ctrl.mul_en = 1'b1;
        ctrl.cap_gl = 1'b1;
        state_nxt   = vgae_pkg::ST_MUL_GLC;
      end
      vgae_pkg::ST_MUL_GLC: begin
        ctrl.op_sel    = vgae_pkg::SEL_GLC;
        ctrl.mul_en    = 1'b1;
        ctrl.cap_delta = 1'b1;
        state_nxt      = vgae_pkg::ST_MUL_TRACE;
      end
      vgae_pkg::ST_MUL_TRACE: begin
        ctrl.op_sel = vgae_pkg::SEL_TRACE;
        ctrl.mul_en = 1'b1;
        state_nxt   = vgae_pkg::ST_FINISH;
      end
      vgae_pkg::ST_FINISH: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt     = vgae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vgae_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/vtrace_gae_advantage_unit.sv
`default_nettype none

// Channel     Dir  Handshake      Payload
// in_item     in   valid/ready    value_now, value_next, reward_next,
//                                 terminated_next, truncated,
//                                 importance_ratio, row_start
// out_result  out  valid/ready    advantage (Q16.16, saturated)
// cfg_*       in   cfg_wr_en      cfg_index, cfg_wdata (no read-back)
//
// A normal step runs through one idle/accept state, five passes through the
// single shared 36x27 multiplier (gamma*v_next, gamma*lambda, rho*inner,
// gl*c, glc*trace) and a finish state that sums, saturates and loads the
// output register; a truncated step goes from idle straight to finish. A
// new step is accepted only in idle, as the multiplies form one chain.
// The output register lets the next step be accepted while the previous
// advantage is still waiting; a stall on out_result only holds the finish
// cycle. Reset (sync, active low) restores the register defaults and zeroes
// the running trace.

module vtrace_gae_advantage_unit (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_wr_en,
  input  wire logic [vgae_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vgae_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  vgae_in_if.sink                                in_item,
  vgae_out_if.source                             out_result
);

  localparam int VW  = vgae_pkg::VAL_W;
  localparam int AW  = vgae_pkg::MUL_A_W;
  localparam int BW  = vgae_pkg::MUL_B_W;
  localparam int RW  = vgae_pkg::MUL_RES_W;
  localparam int SW  = vgae_pkg::SUM_W;
  localparam int CW  = vgae_pkg::COEF_W;
  localparam int QW  = vgae_pkg::RATIO_W;
  localparam int GLW = vgae_pkg::GL_W;

  // Configuration registers
  logic [CW-1:0] discount_r;
  logic [CW-1:0] trace_decay_r;
  logic [QW-1:0] rho_limit_r;
  logic [QW-1:0] trace_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discount_r    <= vgae_pkg::DISCOUNT_RST;
      trace_decay_r <= vgae_pkg::TRACE_DECAY_RST;
      rho_limit_r   <= vgae_pkg::RHO_LIMIT_RST;
      trace_limit_r <= vgae_pkg::TRACE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vgae_pkg::CFG_DISCOUNT:    discount_r    <= cfg_wdata[CW-1:0];
        vgae_pkg::CFG_TRACE_DECAY: trace_decay_r <= cfg_wdata[CW-1:0];
        vgae_pkg::CFG_RHO_LIMIT:   rho_limit_r   <= cfg_wdata[QW-1:0];
        vgae_pkg::CFG_TRACE_LIMIT: trace_limit_r <= cfg_wdata[QW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  vgae_pkg::ctrl_t ctrl;
  logic            in_fire;
  logic            out_valid_r;
  logic            out_free;

  assign in_fire       = in_item.valid && ctrl.idle;
  assign in_item.ready = ctrl.idle;
  assign out_free      = !out_valid_r || out_result.ready;

  vgae_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_trunc (in_item.truncated),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Step operands, captured on the input transaction
  logic signed [VW-1:0] vnow_r;
  logic signed [VW-1:0] vnext_r;
  logic signed [VW-1:0] rnext_r;
  logic                 term_r;
  logic                 trunc_r;
  logic                 start_r;
  logic        [QW-1:0] rho_r;
  logic        [QW-1:0] c_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      vnow_r  <= in_item.value_now;
      vnext_r <= in_item.value_next;
      rnext_r <= in_item.reward_next;
      term_r  <= in_item.terminated_next;
      trunc_r <= in_item.truncated;
      start_r <= in_item.row_start;
      // ratio clipped once for the TD error and once for the trace
      rho_r   <= (in_item.importance_ratio < rho_limit_r) ?
                 in_item.importance_ratio : rho_limit_r;
      c_r     <= (in_item.importance_ratio < trace_limit_r) ?
                 in_item.importance_ratio : trace_limit_r;
    end
  end

  // Shared multiplier and its operand select
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [RW-1:0] prod_r;
  logic signed [AW-1:0] inner_r;
  logic        [GLW-1:0] gl_r;
  logic signed [RW-1:0] delta_r;
  logic signed [VW-1:0] trace_r;
  logic signed [VW-1:0] prev_trace;

  // row start: the recurrence sees zero before this step
  assign prev_trace = start_r ? '0 : trace_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op_sel)
      vgae_pkg::SEL_GV: begin
        mul_a = AW'(vnext_r);
        mul_b = BW'({1'b0, discount_r});
      end
      vgae_pkg::SEL_GL: begin
        mul_a = AW'({1'b0, discount_r});
        mul_b = BW'({1'b0, trace_decay_r});
      end
      vgae_pkg::SEL_DELTA: begin
        mul_a = inner_r;
        mul_b = BW'({1'b0, rho_r});
      end
      vgae_pkg::SEL_GLC: begin
        mul_a = AW'({1'b0, gl_r});
        mul_b = BW'({1'b0, c_r});
      end
      vgae_pkg::SEL_TRACE: begin
        mul_a = AW'(prev_trace);
        mul_b = prod_r[BW-1:0];   // gamma*lambda*c, below 2^26
      end
      default: ;
    endcase
  end

  // product held outside the multiply states, so a stalled finish cycle
  // still sees the trace term
  vgae_mul u_mul (
    .clk    (clk),
    .mul_en (ctrl.mul_en),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // Intermediate captures; a terminal next step drops gamma*v_next
  logic signed [AW-1:0] gv_term;
  assign gv_term = term_r ? '0 : prod_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.cap_inner) begin
      inner_r <= AW'(rnext_r) - AW'(vnow_r) + gv_term;
    end
    if (ctrl.cap_gl) begin
      gl_r <= prod_r[GLW-1:0];
    end
    if (ctrl.cap_delta) begin
      delta_r <= prod_r;
    end
  end

  // Final sum and saturation; trace term also dropped on a terminal step
  logic signed [SW-1:0] sum_w;
  logic signed [VW-1:0] sat_w;
  logic signed [VW-1:0] adv_nxt;
  logic signed [VW-1:0] out_adv_r;

  assign sum_w = SW'(delta_r) + (term_r ? '0 : SW'(prod_r));

  always_comb begin
    if (sum_w > SW'(vgae_pkg::ADV_MAX)) begin
      sat_w = vgae_pkg::ADV_MAX;
    end else if (sum_w < SW'(vgae_pkg::ADV_MIN)) begin
      sat_w = vgae_pkg::ADV_MIN;
    end else begin
      sat_w = sum_w[VW-1:0];
    end
  end

  // truncated step: zero advantage, recurrence cleared
  assign adv_nxt = trunc_r ? '0 : sat_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      trace_r     <= adv_nxt;
      out_valid_r <= 1'b1;
    end else if (out_result.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_adv_r <= adv_nxt;
    end
  end

  assign out_result.valid     = out_valid_r;
  assign out_result.advantage = out_adv_r;

`ifndef ASSERT_OFF
  // A full step reaches the trace multiply right after the four earlier multiplies, with no stall between
  a_step_timing: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_item.truncated |-> ##5 (!ctrl.idle &&
      ctrl.op_sel == vgae_pkg::SEL_TRACE))
    else $error("trace multiply not issued on schedule");

  // Truncated step yields zero and clears the recurrence
  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out && trunc_r |=> (out_adv_r == '0 && trace_r == '0))
    else $error("truncated step not zeroed");

  // Stored trace always matches the advantage just delivered
  a_trace_matches: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |=> (out_valid_r && trace_r == out_adv_r))
    else $error("running trace differs from output");

  // Row start feeds a zero previous trace into the multiplier
  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.idle && ctrl.op_sel == vgae_pkg::SEL_TRACE && start_r |-> mul_a == '0)
    else $error("row start did not clear recurrence input");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vgae_pkg::*;

  // Run limit: about 1300 steps with their worst-case gaps and stalls, plus the
  // long hold-off, the drains and the register phases; several times that.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES = 30;   // well past the length of one step

  localparam logic signed [VAL_W-1:0] ONE = 32'sh0001_0000;

  // One time step as it is offered on the input channel.
  typedef struct {
    logic signed [VAL_W-1:0] value_now;
    logic signed [VAL_W-1:0] value_next;
    logic signed [VAL_W-1:0] reward_next;
    logic terminated_next;
    logic truncated;
    logic [RATIO_W-1:0] importance_ratio;
    logic row_start;
  } step_t;

  // Keeps its own copy of the registers and of the running trace, predicts
  // the advantage of every accepted step and compares it with the block.
  class advantage_scoreboard;
    logic [COEF_W-1:0] discount;
    logic [COEF_W-1:0] trace_decay;
    logic [RATIO_W-1:0] rho_limit;
    logic [RATIO_W-1:0] trace_limit;
    longint running_trace;
    logic signed [VAL_W-1:0] expected_advantage[$];
    int errors;

    function new();
      discount = DISCOUNT_RST;
      trace_decay = TRACE_DECAY_RST;
      rho_limit = RHO_LIMIT_RST;
      trace_limit = TRACE_LIMIT_RST;
      running_trace = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DISCOUNT: discount = data[COEF_W-1:0];
        CFG_TRACE_DECAY: trace_decay = data[COEF_W-1:0];
        CFG_RHO_LIMIT: rho_limit = data;
        CFG_TRACE_LIMIT: trace_limit = data;
        default: ;
      endcase
    endfunction

    // Fixed-point product, rounded to nearest with ties toward +inf.
    function longint round_mul(longint a, longint b);
      return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function longint saturate(longint x);
      if (x > longint'(ADV_MAX))
        return longint'(ADV_MAX);
      if (x < longint'(ADV_MIN))
        return longint'(ADV_MIN);
      return x;
    endfunction

    function void note_step(step_t s);
      longint prev_trace;
      longint rho;
      longint c;
      longint inner;
      longint delta;
      longint trace_term;
      longint gl;
      longint glc;
      prev_trace = s.row_start ? 0 : running_trace;
      if (s.truncated) begin
        running_trace = 0;
        expected_advantage.push_back('0);
        return;
      end
      rho = longint'(s.importance_ratio < rho_limit ? s.importance_ratio : rho_limit);
      c = longint'(s.importance_ratio < trace_limit ? s.importance_ratio : trace_limit);
      inner = longint'(s.reward_next) - longint'(s.value_now);
      if (!s.terminated_next)
        inner += round_mul(longint'(discount), longint'(s.value_next));
      delta = round_mul(rho, inner);
      trace_term = 0;
      if (!s.terminated_next) begin
        gl = round_mul(longint'(discount), longint'(trace_decay));
        glc = round_mul(gl, c);
        trace_term = round_mul(glc, prev_trace);
      end
      running_trace = saturate(delta + trace_term);
      expected_advantage.push_back(running_trace[VAL_W-1:0]);
    endfunction

    function void check_advantage(logic signed [VAL_W-1:0] actual);
      logic signed [VAL_W-1:0] want;
      if (expected_advantage.size() == 0) begin
        $display("%0t: unexpected advantage %0d, nothing pending", $time, actual);
        errors++;
        return;
      end
      want = expected_advantage.pop_front();
      if (actual !== want) begin
        $display("%0t: advantage mismatch: expected %0d, actual %0d", $time, want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_advantage.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vgae_in_if in_if();
  vgae_out_if out_if();

  vtrace_gae_advantage_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_item(in_if),
    .out_result(out_if)
  );

  advantage_scoreboard sb = new();

  // Shared knobs between the stimulus and the result side.
  bit no_idle = 1'b0;        // burst stretches: neither side idles
  bit hold_off_req = 1'b0;   // ask the result side for one long stall
  int cycle_count = 0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: a random stall before each transaction, or
  // one long hold-off on request so the block backs up into its input.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      // ready is only lowered when a stall follows, so it never gets two
      // nonblocking updates in one time step.
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      sb.check_advantage(out_if.advantage);
    end
  end

  function automatic step_t make_step(logic signed [VAL_W-1:0] vnow,
                                      logic signed [VAL_W-1:0] vnext,
                                      logic signed [VAL_W-1:0] rwd,
                                      logic term, logic trunc,
                                      logic [RATIO_W-1:0] ratio, logic start);
    step_t s;
    s.value_now = vnow;
    s.value_next = vnext;
    s.reward_next = rwd;
    s.terminated_next = term;
    s.truncated = trunc;
    s.importance_ratio = ratio;
    s.row_start = start;
    return s;
  endfunction

  // Mostly small Q16.16 values (about +-16.0) so rows stay in range and the
  // recurrence carries real content; extremes and full-width values mixed in.
  function automatic logic signed [VAL_W-1:0] rand_fixed();
    case ($urandom_range(0, 11))
      0: return ADV_MIN;
      1: return ADV_MAX;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  // Ratios cluster around 1.0 so both sides of the clip limits get hit.
  function automatic logic [RATIO_W-1:0] rand_ratio();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return RATIO_W'($urandom);
      default: return RATIO_W'($urandom_range(49152, 81920));
    endcase
  endfunction

  // Offer one step after a random gap and hold it until accepted; the
  // prediction is made at the accepting edge.
  task automatic send_step(step_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value_now <= s.value_now;
    in_if.value_next <= s.value_next;
    in_if.reward_next <= s.reward_next;
    in_if.terminated_next <= s.terminated_next;
    in_if.truncated <= s.truncated;
    in_if.importance_ratio <= s.importance_ratio;
    in_if.row_start <= s.row_start;
    do @(posedge clk); while (!in_if.ready);
    sb.note_step(s);
  endtask

  // Stop offering and wait until every predicted advantage has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write all four registers on consecutive edges, block idle.
  task automatic write_regs(logic [CFG_DATA_W-1:0] disc, logic [CFG_DATA_W-1:0] lam,
                            logic [CFG_DATA_W-1:0] rho, logic [CFG_DATA_W-1:0] clim);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CFG_DATA_W-1:0] data[4];
    idx = '{CFG_DISCOUNT, CFG_TRACE_DECAY, CFG_RHO_LIMIT, CFG_TRACE_LIMIT};
    data = '{disc, lam, rho, clim};
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= data[i];
      @(posedge clk);
      sb.set_reg(idx[i], data[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Random rows fed last step first. value_next of a step is the value_now
  // of the step fed just before it, as in a real rollout. A few rows lose
  // their row_start mark or get a stray one mid-row (broken sequences).
  task automatic run_rows(int n_steps);
    int sent;
    int row_len;
    logic signed [VAL_W-1:0] carry;
    step_t s;
    sent = 0;
    while (sent < n_steps) begin
      row_len = $urandom_range(1, 12);
      carry = rand_fixed();
      for (int k = 0; k < row_len && sent < n_steps; k++) begin
        s.value_next = ($urandom_range(0, 9) == 0) ? rand_fixed() : carry;
        s.value_now = rand_fixed();
        s.reward_next = rand_fixed();
        s.row_start = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
        s.terminated_next = (k == 0) ? 1'($urandom_range(0, 1)) :
                                       ($urandom_range(0, 19) == 0);
        s.truncated = ($urandom_range(0, 11) == 0);
        s.importance_ratio = rand_ratio();
        carry = s.value_now;
        send_step(s);
        sent++;
      end
    end
  endtask

  initial begin
    // Every input known from time zero.
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_DISCOUNT;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.value_now <= '0;
    in_if.value_next <= '0;
    in_if.reward_next <= '0;
    in_if.terminated_next <= 1'b0;
    in_if.truncated <= 1'b0;
    in_if.importance_ratio <= '0;
    in_if.row_start <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed steps under the reset register values.
    send_step(make_step('0, '0, '0, 1'b0, 1'b0, '0, 1'b1));          // all zero
    send_step(make_step(ADV_MIN, ADV_MAX, ADV_MAX, 1'b0, 1'b0, '1, 1'b1)); // sat high
    send_step(make_step(ADV_MAX, ADV_MIN, ADV_MIN, 1'b0, 1'b0, '1, 1'b0)); // sat low
    send_step(make_step(ADV_MAX, ADV_MAX, ADV_MIN, 1'b1, 1'b0, '1, 1'b0)); // terminal
    send_step(make_step(ONE, 2 * ONE, ONE, 1'b0, 1'b0, 24'h010000, 1'b1)); // ratio at clip
    send_step(make_step(ONE, ONE, -ONE, 1'b0, 1'b0, 24'h00FFFF, 1'b0));    // just below
    send_step(make_step(-ONE, ONE, ONE, 1'b0, 1'b0, 24'h010001, 1'b0));    // just above
    send_step(make_step(ADV_MAX, ADV_MAX, ADV_MAX, 1'b0, 1'b1, '1, 1'b0)); // truncated
    send_step(make_step(ONE, ONE, ONE, 1'b0, 1'b0, 24'h010000, 1'b0));     // trace was cleared
    send_step(make_step(ONE, ONE, ONE, 1'b0, 1'b0, '0, 1'b0));             // zero ratio
    send_step(make_step(ADV_MAX, ADV_MIN, ADV_MAX, 1'b1, 1'b0, '1, 1'b1)); // terminal + start
    send_step(make_step(ADV_MIN, ADV_MAX, ADV_MIN, 1'b0, 1'b1, '0, 1'b1)); // trunc + start
    // rounding ties and sub-LSB products
    send_step(make_step(32'sh0000_8000, 32'shFFFF_8000, 32'sh0000_0001,
                        1'b0, 1'b0, 24'h008000, 1'b1));
    send_step(make_step(-1, 1, -1, 1'b0, 1'b0, 24'h000001, 1'b0));
    send_step(make_step('0, ADV_MAX, '0, 1'b0, 1'b0, 24'h010000, 1'b0));
    send_step(make_step('0, ADV_MIN, '0, 1'b0, 1'b0, 24'h010000, 1'b0));
    // short row so the recurrence carries a real value
    send_step(make_step(ONE, 3 * ONE, 2 * ONE, 1'b0, 1'b0, 24'h00C000, 1'b1));
    send_step(make_step(2 * ONE, ONE, -ONE, 1'b0, 1'b0, 24'h018000, 1'b0));
    send_step(make_step(-ONE, 2 * ONE, ONE, 1'b0, 1'b0, 24'h010000, 1'b0));

    // Random phase under the reset values.
    run_rows(180);

    // gamma = lambda = 1.0, clip limits wide open. The result side takes one
    // long hold-off partway through while steps keep being offered.
    write_regs(24'h010000, 24'h010000, 24'hFFFFFF, 24'hFFFFFF);
    run_rows(60);
    hold_off_req = 1'b1;
    run_rows(130);

    // Everything zero: gamma and lambda zero, every ratio clipped to zero.
    write_regs(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    no_idle = 1'b1;
    run_rows(170);
    no_idle = 1'b0;

    // Coefficients above 1.0 (full 17-bit field), trace clip closed.
    write_regs(24'h01FFFF, 24'h01FFFF, 24'hFFFFFF, 24'h000000);
    run_rows(90);
    // Sender pauses until every pending advantage is back.
    wait_drained();
    run_rows(100);

    // Random register values, upper data bits of the narrow fields set too.
    write_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
               CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    run_rows(180);

    // Typical setup: gamma 1.0, lambda zero, rho wide, c clipped at 1.0.
    write_regs(24'h010000, 24'h000000, 24'h7FFFFF, 24'h010000);
    run_rows(180);

    // Random again, gamma and lambda up to 1.0, clip limits up to 4.0.
    write_regs(CFG_DATA_W'($urandom_range(0, 65536)),
               CFG_DATA_W'($urandom_range(0, 65536)),
               CFG_DATA_W'($urandom_range(0, 262144)),
               CFG_DATA_W'($urandom_range(0, 262144)));
    run_rows(180);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
